>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCPC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Invariant checked at every clock edge out of reset.
`define RCPC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

`endif

>>> rtl/rcpc_pkg.sv
// Shared types and constants of the RC pulse capture block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rcpc_pkg;

    localparam int TS_W           = 32;
    localparam int QUOT_W         = 16;
    localparam int WIDTH_W        = 12;
    localparam int STALE_W        = 4;
    localparam int CH_W           = 2;
    localparam int NUM_OUT_WIDTHS = 3;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 40;
    localparam int CFG_ADDR_W     = 1;

    // tuser codes
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_WIDTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_WIDTH = 1'b1;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 12'd800;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 12'd2200;

    // Sideband that travels with a transaction through the divider.
    typedef struct packed {
        logic            tick;
        logic            meas;
        logic [CH_W-1:0] ch;
    } rcpc_tag_t;

endpackage

`default_nettype wire

>>> rtl/rcpc_divc.sv
// Pipelined divide of a 32-bit cycle count by a constant, keeping 16 quotient bits.
// Depends on rcpc_pkg.
`default_nettype none

module rcpc_divc
    import rcpc_pkg::*;
#(
    parameter int CYCLES_PER_US = 72
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [TS_W-1:0]   in_diff,
    input  wire rcpc_tag_t         in_tag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [QUOT_W-1:0]      out_quot,
    output rcpc_tag_t              out_tag
);

    // floor(2^32 / C): the estimate is the true quotient or one below it
    localparam logic [TS_W:0]   RECIP = (TS_W+1)'(64'h1_0000_0000 / 64'(CYCLES_PER_US));
    localparam logic [TS_W-1:0] CYC_W = TS_W'(CYCLES_PER_US);
    // the remainder of the estimate lies below 2*C
    localparam int              RW    = $clog2(2 * CYCLES_PER_US);
    localparam logic [RW-1:0]   CYC_R = RW'(CYCLES_PER_US);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [TS_W-1:0]     d1_reg, d2_reg, d3_reg, d4_reg;
    rcpc_tag_t           tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [TS_W+16:0]    pp_hi_reg;
    logic [TS_W+15:0]    pp_lo_reg;
    logic [TS_W-1:0]     q3_reg, q4_reg;
    logic [TS_W-1:0]     prod4_reg;

    logic [TS_W+16:0]    pp_hi_next;
    logic [TS_W+15:0]    pp_lo_next;
    logic [2*TS_W:0]     sum_next;
    logic [TS_W-1:0]     q3_next;
    logic [TS_W-1:0]     prod4_next;
    logic [RW-1:0]       rem;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign pp_hi_next = (TS_W+17)'(d1_reg) * (TS_W+17)'(RECIP[TS_W:16]);
    assign pp_lo_next = (TS_W+16)'(d1_reg) * (TS_W+16)'(RECIP[15:0]);
    assign sum_next   = {pp_hi_reg, 16'b0} + (2*TS_W+1)'(pp_lo_reg);
    assign q3_next    = sum_next[2*TS_W-1:TS_W];
    assign prod4_next = q3_reg * CYC_W;

    // bump the estimate when the remainder still holds a whole divisor
    assign rem       = d4_reg[RW-1:0] - prod4_reg[RW-1:0];
    assign out_quot  = q4_reg[QUOT_W-1:0] + QUOT_W'(rem >= CYC_R);
    assign out_tag   = tag4_reg;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            d1_reg   <= in_diff;
            tag1_reg <= in_tag;
        end
        if (rdy2)
        begin
            d2_reg    <= d1_reg;
            tag2_reg  <= tag1_reg;
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
        end
        if (rdy3)
        begin
            d3_reg   <= d2_reg;
            tag3_reg <= tag2_reg;
            q3_reg   <= q3_next;
        end
        if (rdy4)
        begin
            d4_reg    <= d3_reg;
            tag4_reg  <= tag3_reg;
            q4_reg    <= q3_reg;
            prod4_reg <= prod4_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rc_pulse_capture_failsafe.sv
// Top level of the RC pulse capture block with link-loss failsafe.
// Depends on rcpc_pkg and rcpc_divc.
//
//   channel  direction  signals                     content
//   s        in         s_tvalid/s_tready/s_tdata   pin edge or tick, kind in s_tuser
//   m        out        m_tvalid/m_tready/m_tdata   three channel widths and active
//   cfg      in         cfg_we/cfg_addr/cfg_wdata   min_width, max_width
//
// One transaction per cycle in while s_tready is high, one result per transaction out.
// A result passes through four divider stages and the result register; the
// reciprocal multiply is split over two of the divider stages.
// rst_n clears rise times, widths, staleness counters and active; limits go to 800/2200.
// A stall on m holds the result register; earlier stages keep filling their free slots.
`default_nettype none

module rc_pulse_capture_failsafe
    import rcpc_pkg::*;
#(
    parameter int CYCLES_PER_US = 72,
    parameter int NUM_CHANNELS  = 3,
    parameter int STALE_LIMIT   = 15
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // channel[1:0], level[2], timestamp[34:3]
    input  wire logic                  s_tuser,   // kind[0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // width_a[11:0], width_b[23:12],
                                                  // width_c[35:24], active[36]
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [WIDTH_W-1:0]    cfg_wdata
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [STALE_W-1:0] LIMIT = STALE_W'(STALE_LIMIT);

    logic [WIDTH_W-1:0] min_width_reg, max_width_reg;
    logic [TS_W-1:0]    rise_time_reg   [NUM_CHANNELS];
    logic [WIDTH_W-1:0] pulse_width_reg [NUM_CHANNELS];
    logic [STALE_W-1:0] stale_cnt_reg   [NUM_CHANNELS];
    logic               active_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [WIDTH_W-1:0] pulse_width_next [NUM_CHANNELS];
    logic [STALE_W-1:0] stale_cnt_next   [NUM_CHANNELS];
    logic               active_next;
    logic [WIDTH_W-1:0] width_out [NUM_OUT_WIDTHS];

    logic [CH_W-1:0]     in_ch;
    logic                in_lvl;
    logic [TS_W-1:0]     in_ts;
    logic                in_ch_ok;
    logic [CH_IDX_W-1:0] in_idx;
    logic [TS_W-1:0]     rise_sel;
    logic [TS_W-1:0]     diff;
    logic                s_acc;
    rcpc_tag_t           in_tag;

    logic                div_valid;
    logic                div_ready;
    logic [QUOT_W-1:0]   div_quot;
    rcpc_tag_t           div_tag;
    logic [CH_IDX_W-1:0] out_idx;
    logic                out_load;
    logic                any_stale;
    logic                w_ok;

    assign in_ch    = s_tdata[CH_W-1:0];
    assign in_lvl   = s_tdata[CH_W];
    assign in_ts    = s_tdata[CH_W+TS_W:CH_W+1];
    assign in_ch_ok = 32'(in_ch) < NUM_CHANNELS;
    assign in_idx   = CH_IDX_W'(in_ch);
    assign rise_sel = in_ch_ok ? rise_time_reg[in_idx] : '0;
    assign diff     = in_ts - rise_sel;
    assign s_acc    = s_tvalid && s_tready;

    assign in_tag.tick = (s_tuser == KIND_TICK);
    assign in_tag.meas = (s_tuser == KIND_EDGE) && !in_lvl && in_ch_ok;
    assign in_tag.ch   = in_ch;

    rcpc_divc #(
        .CYCLES_PER_US (CYCLES_PER_US)
    ) u_divc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_diff   (diff),
        .in_tag    (in_tag),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quot  (div_quot),
        .out_tag   (div_tag)
    );

    assign div_ready = !m_tvalid_reg || m_tready;
    assign out_load  = div_valid && div_ready;
    assign out_idx   = CH_IDX_W'(div_tag.ch);
    assign w_ok      = (div_quot > QUOT_W'(min_width_reg)) && (div_quot < QUOT_W'(max_width_reg));

    always_comb
    begin
        any_stale = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (stale_cnt_reg[i] >= LIMIT)
            begin
                any_stale = 1'b1;
            end
        end
    end

    always_comb
    begin
        pulse_width_next = pulse_width_reg;
        stale_cnt_next   = stale_cnt_reg;
        active_next      = active_reg;
        if (div_tag.tick)
        begin
            if (!any_stale)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    stale_cnt_next[i] = stale_cnt_reg[i] + STALE_W'(1);
                end
                active_next = 1'b1;
            end
            else
            begin
                // failsafe: drop all widths, counters hold
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    pulse_width_next[i] = '0;
                end
                active_next = 1'b0;
            end
        end
        else if (div_tag.meas && w_ok)
        begin
            pulse_width_next[out_idx] = div_quot[WIDTH_W-1:0];
            stale_cnt_next[out_idx]   = '0;
        end
    end

    for (genvar j = 0; j < NUM_OUT_WIDTHS; j++)
    begin : g_out
        if (j < NUM_CHANNELS)
        begin : g_used
            assign width_out[j] = pulse_width_next[j];
        end
        else
        begin : g_none
            assign width_out[j] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg <= MIN_WIDTH_RST;
            max_width_reg <= MAX_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_WIDTH: min_width_reg <= cfg_wdata;
                REG_MAX_WIDTH: max_width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rise_time_reg[i] <= '0;
            end
        end
        else if (s_acc && (s_tuser == KIND_EDGE) && in_lvl && in_ch_ok)
        begin
            rise_time_reg[in_idx] <= in_ts;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pulse_width_reg[i] <= '0;
                stale_cnt_reg[i]   <= '0;
            end
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                pulse_width_reg <= pulse_width_next;
                stale_cnt_reg   <= stale_cnt_next;
                active_reg      <= active_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {(M_TDATA_W-3*WIDTH_W-1)'(0), active_next,
                            width_out[2], width_out[1], width_out[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/rcpc_checker.sv
// Port-level checks of the RC pulse capture block, bound to the top level.
// Depends on rcpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rcpc_checker
    import rcpc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // transactions in flight: four divider stages plus the result register
    localparam logic [2:0] MAX_PENDING = 3'd5;

    logic [2:0] pending_reg;
    logic       prev_active_reg;
    logic       in_acc;
    logic       out_acc;
    logic       out_active;
    logic [3*WIDTH_W-1:0] out_widths;
    logic       drop_link;

    assign in_acc     = s_tvalid && s_tready;
    assign out_acc    = m_tvalid && m_tready;
    assign out_active = m_tdata[3*WIDTH_W];
    assign out_widths = m_tdata[3*WIDTH_W-1:0];
    // link went down between two consecutive results
    assign drop_link  = out_acc && prev_active_reg && !out_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            prev_active_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_acc) - 3'(out_acc);
            if (out_acc)
            begin
                prev_active_reg <= out_active;
            end
        end
    end

    `RCPC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RCPC_ASSERT_IMPLY(a_no_invented, clk, rst_n, m_tvalid, pending_reg != 3'd0)
    `RCPC_ASSERT_ALWAYS(a_pending_bound, clk, rst_n, pending_reg <= MAX_PENDING)
    `RCPC_ASSERT_IMPLY(a_failsafe_clear, clk, rst_n, drop_link, out_widths == '0)

endmodule

bind rc_pulse_capture_failsafe rcpc_checker u_rcpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
